[src/periodic_task_dispatcher_assert.svh]
// Assertion macros shared by the periodic task dispatcher RTL.
// Depends on a clock named aclk and an active-low reset named aresetn in scope.
`ifndef PERIODIC_TASK_DISPATCHER_ASSERT_SVH
`define PERIODIC_TASK_DISPATCHER_ASSERT_SVH

// Check that a condition implies another in the same cycle.
`define PTD_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("periodic_task_dispatcher: same-cycle check failed");

// Check that a condition implies another in the following cycle.
`define PTD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("periodic_task_dispatcher: next-cycle check failed");

`endif

[src/ptd_pkg.sv]
// Shared types and constants for the periodic task dispatcher.
// No dependencies; used by ptd_ctrl, ptd_datapath and periodic_task_dispatcher.
package ptd_pkg;

    localparam int ACTION_W  = 3;
    localparam int KEY_W     = 8;
    localparam int TIME_W    = 32;
    localparam int PRIO_W    = 3;
    localparam int STATUS_W  = 2;
    localparam int TOTAL_W   = 5;
    localparam int S_TDATA_W = 80;
    localparam int M_TDATA_W = 16;

    typedef enum logic [ACTION_W-1:0] {
        ACT_RUN     = 3'd0,
        ACT_ADD     = 3'd1,
        ACT_SUSPEND = 3'd2,
        ACT_RESUME  = 3'd3,
        ACT_DELETE  = 3'd4
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_REJECT  = 2'd1,
        ST_MISSING = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_APPLY,
        S_SHIFT,
        S_DONE
    } state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic scan;
        logic apply;
        logic shift;
        logic shrink;
        logic emit;
    } ctrl_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic sweep_done;
        logic del_shift;
    } dp_stat_t;

endpackage

[src/ptd_ctrl.sv]
// Controller state machine of the periodic task dispatcher.
// Depends on ptd_pkg; drives the command struct of ptd_datapath.
module ptd_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic             m_free,
    input  ptd_pkg::dp_stat_t  stat,
    output ptd_pkg::ctrl_cmd_t cmd
);
    import ptd_pkg::*;

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                cmd.scan = 1'b1;
                if (stat.sweep_done) begin
                    state_next = S_APPLY;
                end
            end
            S_APPLY: begin
                cmd.apply = 1'b1;
                if (stat.del_shift) begin
                    state_next = S_SHIFT;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_SHIFT: begin
                cmd.shift = 1'b1;
                if (stat.sweep_done) begin
                    cmd.shrink = 1'b1;
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (m_free) begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

[src/ptd_datapath.sv]
// Datapath of the periodic task dispatcher: task table memories, scan trackers,
// compaction sweep and result registers. Depends on ptd_pkg.
module ptd_datapath #(
    parameter int TASK_SLOTS = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  ptd_pkg::ctrl_cmd_t             cmd,
    input  logic [ptd_pkg::ACTION_W-1:0]   in_action,
    input  logic [ptd_pkg::KEY_W-1:0]      in_task_key,
    input  logic [ptd_pkg::TIME_W-1:0]     in_period_ms,
    input  logic [ptd_pkg::PRIO_W-1:0]     in_priority_req,
    input  logic [ptd_pkg::TIME_W-1:0]     in_now_ms,
    output ptd_pkg::dp_stat_t              stat,
    output logic [ptd_pkg::STATUS_W-1:0]   res_status,
    output logic                           res_run_valid,
    output logic [ptd_pkg::KEY_W-1:0]      res_run_task_key,
    output logic [ptd_pkg::TOTAL_W-1:0]    res_task_total
);
    import ptd_pkg::*;

    localparam int AW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
    localparam int CW = $clog2(TASK_SLOTS + 1);
    localparam int EW = CW + TOTAL_W;

    // Task table, one array per field, common address
    logic [KEY_W-1:0]  key_mem    [TASK_SLOTS];
    logic [TIME_W-1:0] period_mem [TASK_SLOTS];
    logic [TIME_W-1:0] last_mem   [TASK_SLOTS];
    logic [PRIO_W-1:0] prio_mem   [TASK_SLOTS];
    logic              en_mem     [TASK_SLOTS];

    logic [KEY_W-1:0]  rd_key_reg;
    logic [TIME_W-1:0] rd_period_reg;
    logic [TIME_W-1:0] rd_last_reg;
    logic [PRIO_W-1:0] rd_prio_reg;
    logic              rd_en_reg;

    logic [AW-1:0]     wr_addr;
    logic              we_key, we_period, we_last, we_prio, we_en;
    logic [KEY_W-1:0]  wd_key;
    logic [TIME_W-1:0] wd_period;
    logic [TIME_W-1:0] wd_last;
    logic [PRIO_W-1:0] wd_prio;
    logic              wd_en;
    logic [AW-1:0]     rd_addr;

    // Latched item
    logic [ACTION_W-1:0] act_reg;
    logic [KEY_W-1:0]    key_in_reg;
    logic [TIME_W-1:0]   period_in_reg;
    logic [PRIO_W-1:0]   prio_in_reg;
    logic [TIME_W-1:0]   now_reg;

    // Sweep control
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] ptr_reg, ptr_next;
    logic          rd_vld_reg;
    logic [AW-1:0] rd_idx_reg;
    logic          issue;

    // Scan trackers
    logic              match_vld_reg;
    logic [AW-1:0]     match_idx_reg;
    logic [PRIO_W-1:0] best_prio_reg;
    logic [AW-1:0]     best_idx_reg;
    logic [KEY_W-1:0]  best_key_reg;
    logic [TIME_W-1:0] elapsed;
    logic              due;
    logic              better;
    logic              key_hit;
    logic              best_found;
    logic              full;
    logic              add_ok;

    // Results
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic                res_valid_reg, res_valid_next;
    logic [KEY_W-1:0]    res_key_reg, res_key_next;
    logic [EW-1:0]       cnt_ext;

    // Memory ports
    always_ff @(posedge aclk) begin
        if (we_key) begin
            key_mem[wr_addr] <= wd_key;
        end
        rd_key_reg <= key_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (we_period) begin
            period_mem[wr_addr] <= wd_period;
        end
        rd_period_reg <= period_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (we_last) begin
            last_mem[wr_addr] <= wd_last;
        end
        rd_last_reg <= last_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (we_prio) begin
            prio_mem[wr_addr] <= wd_prio;
        end
        rd_prio_reg <= prio_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (we_en) begin
            en_mem[wr_addr] <= wd_en;
        end
        rd_en_reg <= en_mem[rd_addr];
    end

    // Entry evaluation on the registered read data
    assign elapsed    = now_reg - rd_last_reg;
    assign due        = rd_en_reg && (elapsed >= rd_period_reg);
    assign better     = due && (rd_prio_reg > best_prio_reg);
    assign key_hit    = (rd_key_reg == key_in_reg);
    assign best_found = (best_prio_reg != '0);
    assign full       = (cnt_reg >= CW'(TASK_SLOTS));
    assign add_ok     = !full && !match_vld_reg;

    assign issue   = (cmd.scan || cmd.shift) && (ptr_reg < cnt_reg);
    assign rd_addr = ptr_reg[AW-1:0];

    // Write port and result selection
    always_comb begin
        wr_addr         = '0;
        we_key          = 1'b0;
        we_period       = 1'b0;
        we_last         = 1'b0;
        we_prio         = 1'b0;
        we_en           = 1'b0;
        wd_key          = rd_key_reg;
        wd_period       = rd_period_reg;
        wd_last         = rd_last_reg;
        wd_prio         = rd_prio_reg;
        wd_en           = rd_en_reg;
        res_status_next = ST_OK;
        res_valid_next  = 1'b0;
        res_key_next    = '0;
        if (cmd.apply) begin
            case (act_reg)
                ACT_RUN: begin
                    if (best_found) begin
                        wr_addr        = best_idx_reg;
                        we_last        = 1'b1;
                        wd_last        = now_reg;
                        res_valid_next = 1'b1;
                        res_key_next   = best_key_reg;
                    end
                end
                ACT_ADD: begin
                    if (add_ok) begin
                        wr_addr   = cnt_reg[AW-1:0];
                        we_key    = 1'b1;
                        we_period = 1'b1;
                        we_last   = 1'b1;
                        we_prio   = 1'b1;
                        we_en     = 1'b1;
                        wd_key    = key_in_reg;
                        wd_period = period_in_reg;
                        wd_last   = '0;
                        wd_prio   = prio_in_reg;
                        wd_en     = 1'b1;
                    end else begin
                        res_status_next = ST_REJECT;
                    end
                end
                ACT_SUSPEND: begin
                    if (match_vld_reg) begin
                        wr_addr = match_idx_reg;
                        we_en   = 1'b1;
                        wd_en   = 1'b0;
                    end else begin
                        res_status_next = ST_MISSING;
                    end
                end
                ACT_RESUME: begin
                    if (match_vld_reg) begin
                        wr_addr = match_idx_reg;
                        we_en   = 1'b1;
                        wd_en   = 1'b1;
                        we_last = 1'b1;
                        wd_last = now_reg;
                    end else begin
                        res_status_next = ST_MISSING;
                    end
                end
                ACT_DELETE: begin
                    if (!match_vld_reg) begin
                        res_status_next = ST_MISSING;
                    end
                end
                default: begin
                    res_status_next = ST_OK;
                end
            endcase
        end else if (cmd.shift && rd_vld_reg) begin
            // Move the entry just read down by one place
            wr_addr   = rd_idx_reg - AW'(1);
            we_key    = 1'b1;
            we_period = 1'b1;
            we_last   = 1'b1;
            we_prio   = 1'b1;
            we_en     = 1'b1;
        end
    end

    // Entry count and sweep pointer
    always_comb begin
        cnt_next = cnt_reg;
        if (cmd.apply && (act_reg == ACT_ADD) && add_ok) begin
            cnt_next = cnt_reg + CW'(1);
        end else if (cmd.shrink) begin
            cnt_next = cnt_reg - CW'(1);
        end
        ptr_next = ptr_reg;
        if (cmd.load) begin
            ptr_next = '0;
        end else if (cmd.apply) begin
            ptr_next = CW'(match_idx_reg) + CW'(1);
        end else if (issue) begin
            ptr_next = ptr_reg + CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg    <= '0;
            ptr_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end else begin
            cnt_reg    <= cnt_next;
            ptr_reg    <= ptr_next;
            rd_vld_reg <= issue;
        end
    end

    // Latch item, track first key match and best due task
    always_ff @(posedge aclk) begin
        if (issue) begin
            rd_idx_reg <= ptr_reg[AW-1:0];
        end
        if (cmd.load) begin
            act_reg       <= in_action;
            key_in_reg    <= in_task_key;
            period_in_reg <= in_period_ms;
            prio_in_reg   <= in_priority_req;
            now_reg       <= in_now_ms;
            match_vld_reg <= 1'b0;
            match_idx_reg <= '0;
            best_prio_reg <= '0;
            best_idx_reg  <= '0;
            best_key_reg  <= '0;
        end else if (cmd.scan && rd_vld_reg) begin
            if (key_hit && !match_vld_reg) begin
                match_vld_reg <= 1'b1;
                match_idx_reg <= rd_idx_reg;
            end
            if (better) begin
                best_prio_reg <= rd_prio_reg;
                best_idx_reg  <= rd_idx_reg;
                best_key_reg  <= rd_key_reg;
            end
        end
        if (cmd.apply) begin
            res_status_reg <= res_status_next;
            res_valid_reg  <= res_valid_next;
            res_key_reg    <= res_key_next;
        end
    end

    assign stat.sweep_done = (ptr_reg >= cnt_reg) && !rd_vld_reg;
    assign stat.del_shift  = (act_reg == ACT_DELETE) && match_vld_reg;

    assign cnt_ext          = EW'(cnt_reg);
    assign res_status       = res_status_reg;
    assign res_run_valid    = res_valid_reg;
    assign res_run_task_key = res_key_reg;
    assign res_task_total   = cnt_ext[TOTAL_W-1:0];

endmodule

[src/periodic_task_dispatcher.sv]
// Periodic task dispatcher: a table of up to TASK_SLOTS periodic tasks with run,
// add, suspend, resume and delete commands, one result transfer per command
// transfer. Each command sweeps the table, reading one table entry per cycle
// from the single read port. A delete that finds its key then compacts the
// table, shifting each entry behind the removed one down by one place. One item
// is worked on at a time, and a stalled result register holds the next result
// back. A new item is accepted as soon as the previous result sits in the output
// register.
// Depends on ptd_pkg, ptd_ctrl, ptd_datapath and the assertion macro header.
module periodic_task_dispatcher #(
    parameter int TASK_SLOTS = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // task_key[7:0], period_ms[39:8], priority_req[42:40], now_ms[74:43]
    input  logic [ptd_pkg::S_TDATA_W-1:0]   s_tdata,
    // action[2:0]
    input  logic [ptd_pkg::ACTION_W-1:0]    s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // status[1:0], run_valid[2], run_task_key[10:3], task_total[15:11]
    output logic [ptd_pkg::M_TDATA_W-1:0]   m_tdata
);
    import ptd_pkg::*;

    `include "periodic_task_dispatcher_assert.svh"

    ctrl_cmd_t cmd;
    dp_stat_t  stat;
    logic      m_free;

    logic [STATUS_W-1:0] res_status;
    logic                res_run_valid;
    logic [KEY_W-1:0]    res_run_task_key;
    logic [TOTAL_W-1:0]  res_task_total;

    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    assign m_free = !m_tvalid_reg || m_tready;

    ptd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_free   (m_free),
        .stat     (stat),
        .cmd      (cmd)
    );

    ptd_datapath #(
        .TASK_SLOTS (TASK_SLOTS)
    ) u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .in_action        (s_tuser),
        .in_task_key      (s_tdata[7:0]),
        .in_period_ms     (s_tdata[39:8]),
        .in_priority_req  (s_tdata[42:40]),
        .in_now_ms        (s_tdata[74:43]),
        .stat             (stat),
        .res_status       (res_status),
        .res_run_valid    (res_run_valid),
        .res_run_task_key (res_run_task_key),
        .res_task_total   (res_task_total)
    );

    // Output register: load on emit, drop once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_tdata_reg <= {res_task_total, res_run_task_key, res_run_valid, res_status};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Checks
    `PTD_ASSERT_SAME(a_emit_into_free_slot, cmd.emit, m_free)
    `PTD_ASSERT_NEXT(a_one_item_in_flight, s_tvalid && s_tready, !s_tready)
    `PTD_ASSERT_SAME(a_run_hit_is_ok, m_tvalid && m_tdata[2], m_tdata[1:0] == ST_OK)

endmodule
